/* rtl/core/ppgrf_pkg.sv */
`timescale 1ns / 1ps

package ppgrf_pkg;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_SAMPLE = 2'd3
    } mode_t;

    localparam logic [7:0] A_ISR1 = 8'h00;
    localparam logic [7:0] A_ISR2 = 8'h01;
    localparam logic [7:0] A_WPTR = 8'h04;
    localparam logic [7:0] A_RPTR = 8'h06;
    localparam logic [7:0] A_DATA = 8'h07;
    localparam logic [7:0] A_FCFG = 8'h08;
    localparam logic [7:0] A_MODE = 8'h09;
    localparam logic [7:0] A_PCFG = 8'h0A;
    localparam logic [7:0] A_LED1 = 8'h0C;
    localparam logic [7:0] A_LED2 = 8'h0D;
    localparam logic [7:0] A_REV  = 8'hFE;
    localparam logic [7:0] A_PART = 8'hFF;

    localparam logic [7:0] RDY_BIT  = 8'h40;
    localparam int         SRST_POS = 6;
    localparam int         SHDN_POS = 7;

    localparam logic [7:0] PART_ID_DEFAULT = 8'h15;
    localparam logic [7:0] FCFG_DEFAULT    = 8'h10;
    localparam logic [7:0] MODE_DEFAULT    = 8'h03;
    localparam logic [7:0] PCFG_DEFAULT    = 8'h04;
    localparam logic [7:0] LED_DEFAULT     = 8'h1F;

    // six bytes per pair: red high/mid/low, then infrared high/mid/low
    localparam logic [2:0] LAST_BYTE_POS = 3'd5;
    localparam int         BYTE_SPAN     = 24;

    localparam int REG_DEPTH = 256;

    function automatic logic [7:0] reg_default(input logic [7:0] addr);
        logic [7:0] val;
        unique case (addr)
            A_PART:         val = PART_ID_DEFAULT;
            A_FCFG:         val = FCFG_DEFAULT;
            A_MODE:         val = MODE_DEFAULT;
            A_PCFG:         val = PCFG_DEFAULT;
            A_LED1, A_LED2: val = LED_DEFAULT;
            default:        val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

/* rtl/core/ppgrf_ram.sv */
`timescale 1ns / 1ps

module ppgrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/ppg_sensor_register_fifo.sv */
`timescale 1ns / 1ps

// Register interface and sample FIFO of an optical pulse sensor. Each input word is one
// of four kinds (tuser): write-transaction start, bus write byte, bus read byte, or a
// red/infrared sample pair; every input word yields exactly one output word carrying the
// read byte and the sample-taken and oldest-dropped flags. An item passes through the
// accepting state, whose edge also registers the register RAM and FIFO RAM reads at the
// current pointers, an execute state that uses that read data and writes back, and a
// state that loads the output register. A new word is taken only once the last item
// has loaded its result into the output register. A result still waiting on the output
// holds that last state until it is taken, and the next item may be accepted while one
// result waits. The 256-byte register file sits in a RAM with a valid bit per entry, so
// neither reset nor a soft reset needs a clearing pass; the interrupt status 1, mode and
// FIFO pointer registers live in flops because samples, data reads and soft resets
// update them.
module ppg_sensor_register_fifo #(
    parameter int FIFO_ENTRIES = 32,
    parameter int SAMPLE_BITS  = 18,
    localparam int IN_W = ((2 * SAMPLE_BITS + 15) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // bus_data, red_sample, ir_sample (low bit up), zero padded
    input  logic [IN_W-1:0]   s_tdata,
    // mode
    input  ppgrf_pkg::mode_t  s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // read_data, sample_taken, oldest_dropped (low bit up), zero padded
    output logic [15:0]       m_tdata
);

    import ppgrf_pkg::*;

    localparam int IW = $clog2(FIFO_ENTRIES);
    localparam int FW = 2 * SAMPLE_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    mode_t                  kind_reg;
    logic [7:0]             bus_data_reg;
    logic [SAMPLE_BITS-1:0] red_reg;
    logic [SAMPLE_BITS-1:0] ir_reg;

    logic [7:0]             pointer_reg, pointer_next;
    logic                   ptr_load_reg, ptr_load_next;
    logic [IW-1:0]          wi_reg, wi_next;
    logic [IW-1:0]          ri_reg, ri_next;
    logic [2:0]             pos_reg, pos_next;
    logic [7:0]             isr1_reg, isr1_next;
    logic [7:0]             mode_cfg_reg, mode_cfg_next;
    logic [REG_DEPTH-1:0]   valid_reg, valid_next;

    logic [7:0]             res_data_reg, res_data_next;
    logic                   res_taken_reg, res_taken_next;
    logic                   res_drop_reg, res_drop_next;
    logic                   m_valid_reg, m_valid_next;
    logic [15:0]            m_data_reg, m_data_next;

    logic                   reg_we;
    logic [7:0]             reg_wdata;
    logic [7:0]             reg_q;
    logic                   fifo_we;
    logic [FW-1:0]          fifo_q;

    logic [IW-1:0]          mod_tab [256];
    logic [IW-1:0]          wi_wrap, ri_wrap;
    logic [7:0]             reg_value;
    logic [BYTE_SPAN-1:0]   red_wide, ir_wide;
    logic [7:0]             data_byte;
    logic [REG_DEPTH-1:0]   keep_ids;

    // pointer register writes wrap the byte to the FIFO depth
    for (genvar g = 0; g < 256; g++)
    begin : g_mod
        assign mod_tab[g] = IW'(g % FIFO_ENTRIES);
    end

    ppgrf_ram #(
        .WIDTH (8),
        .DEPTH (REG_DEPTH)
    ) u_reg_ram (
        .clk   (clk),
        .we    (reg_we),
        .waddr (pointer_reg),
        .wdata (reg_wdata),
        .raddr (pointer_reg),
        .rdata (reg_q)
    );

    ppgrf_ram #(
        .WIDTH (FW),
        .DEPTH (FIFO_ENTRIES)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (wi_reg),
        .wdata ({ir_reg, red_reg}),
        .raddr (ri_reg),
        .rdata (fifo_q)
    );

    assign wi_wrap = (wi_reg == IW'(FIFO_ENTRIES - 1)) ? '0 : wi_reg + IW'(1);
    assign ri_wrap = (ri_reg == IW'(FIFO_ENTRIES - 1)) ? '0 : ri_reg + IW'(1);

    always_comb
    begin
        keep_ids         = '0;
        keep_ids[A_REV]  = 1'b1;
        keep_ids[A_PART] = 1'b1;
    end

    // status 1, mode and FIFO pointers come from flops, the rest from RAM or, if never written, defaults
    always_comb
    begin
        priority if (pointer_reg == A_ISR1)
            reg_value = isr1_reg;
        else if (pointer_reg == A_WPTR)
            reg_value = 8'(wi_reg);
        else if (pointer_reg == A_RPTR)
            reg_value = 8'(ri_reg);
        else if (pointer_reg == A_MODE)
            reg_value = mode_cfg_reg;
        else if (valid_reg[pointer_reg])
            reg_value = reg_q;
        else
            reg_value = reg_default(pointer_reg);
    end

    assign red_wide = BYTE_SPAN'(fifo_q[SAMPLE_BITS-1:0]);
    assign ir_wide  = BYTE_SPAN'(fifo_q[FW-1:SAMPLE_BITS]);

    always_comb
    begin
        unique case (pos_reg)
            3'd0:    data_byte = red_wide[23:16];
            3'd1:    data_byte = red_wide[15:8];
            3'd2:    data_byte = red_wide[7:0];
            3'd3:    data_byte = ir_wide[23:16];
            3'd4:    data_byte = ir_wide[15:8];
            3'd5:    data_byte = ir_wide[7:0];
            default: data_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pointer_next   = pointer_reg;
        ptr_load_next  = ptr_load_reg;
        wi_next        = wi_reg;
        ri_next        = ri_reg;
        pos_next       = pos_reg;
        isr1_next      = isr1_reg;
        mode_cfg_next  = mode_cfg_reg;
        valid_next     = valid_reg;
        res_data_next  = res_data_reg;
        res_taken_next = res_taken_reg;
        res_drop_next  = res_drop_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        reg_we         = 1'b0;
        reg_wdata      = bus_data_reg;
        fifo_we        = 1'b0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res_data_next  = 8'h00;
                res_taken_next = 1'b0;
                res_drop_next  = 1'b0;
                state_next     = ST_DONE;
                unique case (kind_reg)
                    MODE_START:
                    begin
                        ptr_load_next = 1'b1;
                    end

                    MODE_WRITE:
                    begin
                        if (ptr_load_reg)
                        begin
                            pointer_next  = bus_data_reg;
                            ptr_load_next = 1'b0;
                        end
                        else
                        begin
                            pointer_next = pointer_reg + 8'd1;
                            priority if (pointer_reg == A_MODE)
                            begin
                                if (bus_data_reg[SRST_POS])
                                begin
                                    // soft reset: defaults back, ids kept
                                    mode_cfg_next = MODE_DEFAULT;
                                    isr1_next     = 8'h00;
                                    wi_next       = '0;
                                    ri_next       = '0;
                                    pos_next      = 3'd0;
                                    valid_next    = valid_reg & keep_ids;
                                end
                                else
                                begin
                                    mode_cfg_next = bus_data_reg;
                                end
                            end
                            else if (pointer_reg == A_WPTR)
                            begin
                                wi_next = mod_tab[bus_data_reg];
                            end
                            else if (pointer_reg == A_RPTR)
                            begin
                                ri_next  = mod_tab[bus_data_reg];
                                pos_next = 3'd0;
                            end
                            else if (pointer_reg == A_ISR1)
                            begin
                                isr1_next = bus_data_reg;
                            end
                            else
                            begin
                                reg_we                  = 1'b1;
                                valid_next[pointer_reg] = 1'b1;
                            end
                        end
                    end

                    MODE_READ:
                    begin
                        if (pointer_reg == A_DATA)
                        begin
                            if (wi_reg != ri_reg)
                            begin
                                res_data_next = data_byte;
                                if (pos_reg == LAST_BYTE_POS)
                                begin
                                    pos_next = 3'd0;
                                    ri_next  = ri_wrap;
                                    if (wi_reg == ri_wrap)
                                    begin
                                        isr1_next = isr1_reg & ~RDY_BIT;
                                    end
                                end
                                else
                                begin
                                    pos_next = pos_reg + 3'd1;
                                end
                            end
                        end
                        else
                        begin
                            res_data_next = reg_value;
                            pointer_next  = pointer_reg + 8'd1;
                            if (pointer_reg == A_ISR1)
                            begin
                                isr1_next = 8'h00;
                            end
                            else if (pointer_reg == A_ISR2)
                            begin
                                reg_we                  = 1'b1;
                                reg_wdata               = 8'h00;
                                valid_next[pointer_reg] = 1'b1;
                            end
                        end
                    end

                    MODE_SAMPLE:
                    begin
                        if (!mode_cfg_reg[SHDN_POS])
                        begin
                            // full: drop the oldest pair to keep one slot free
                            if (wi_wrap == ri_reg)
                            begin
                                ri_next       = ri_wrap;
                                res_drop_next = 1'b1;
                            end
                            fifo_we        = 1'b1;
                            wi_next        = wi_wrap;
                            isr1_next      = isr1_reg | RDY_BIT;
                            res_taken_next = 1'b1;
                        end
                    end

                    default:
                    begin
                    end
                endcase
            end

            ST_DONE:
            begin
                // hold until the output register frees up
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, res_drop_reg, res_taken_reg, res_data_reg};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pointer_reg  <= 8'h00;
            ptr_load_reg <= 1'b0;
            wi_reg       <= '0;
            ri_reg       <= '0;
            pos_reg      <= 3'd0;
            isr1_reg     <= 8'h00;
            mode_cfg_reg <= MODE_DEFAULT;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= 16'h0000;
        end
        else
        begin
            state_reg    <= state_next;
            pointer_reg  <= pointer_next;
            ptr_load_reg <= ptr_load_next;
            wi_reg       <= wi_next;
            ri_reg       <= ri_next;
            pos_reg      <= pos_next;
            isr1_reg     <= isr1_next;
            mode_cfg_reg <= mode_cfg_next;
            valid_reg    <= valid_next;
            m_valid_reg  <= m_valid_next;
            m_data_reg   <= m_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            kind_reg     <= s_tuser;
            bus_data_reg <= s_tdata[7:0];
            red_reg      <= s_tdata[8 +: SAMPLE_BITS];
            ir_reg       <= s_tdata[8 + SAMPLE_BITS +: SAMPLE_BITS];
        end
        res_data_reg  <= res_data_next;
        res_taken_reg <= res_taken_next;
        res_drop_reg  <= res_drop_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
